[src/mct_pkg.sv]
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types and constants for the multiset count table.
// ----------------------------------------------------------------------------
`default_nettype none

package mct_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_COUNT_BITS  = 16;

  localparam int KEY_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int KCOUNT_W  = 16;
  localparam int PURGED_W  = 22;
  localparam int DISTINCT_W = 7;
  localparam int TOTAL_W   = 22;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_PURGE  = 2'd3
  } mct_cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_SAT       = 2'd3
  } mct_status_t;

  typedef struct packed {
    mct_cmd_t          cmd;
    logic [KEY_W-1:0]  key;
  } mct_req_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]    total_size;
    logic [DISTINCT_W-1:0] distinct_keys;
    logic [PURGED_W-1:0]   purged_total;
    logic [KCOUNT_W-1:0]   key_count;
    logic                  present;
    mct_status_t           status;
  } mct_result_t;

endpackage

`default_nettype wire

[src/mct_ram.sv]
// ----------------------------------------------------------------------------
// mct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/mct_engine.sv]
// ----------------------------------------------------------------------------
// mct_engine
// Scan sequencer: one pass over the stored entries finds the key, updates its
// count or purges multiples, and compacts the table in place; a final step appends or reports.
// ----------------------------------------------------------------------------
`default_nettype none

module mct_engine #(
  parameter int TABLE_DEPTH = mct_pkg::DEF_TABLE_DEPTH,
  parameter int COUNT_BITS  = mct_pkg::DEF_COUNT_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire mct_pkg::mct_req_t   req_in,
  output logic                     ready,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output mct_pkg::mct_result_t     res
);
  import mct_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = AW + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [UW-1:0] DEPTH_U = UW'(TABLE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH, S_OUT} state_t;

  state_t                state;
  mct_req_t              req;
  logic [UW-1:0]         used;
  logic [TW-1:0]         total;
  logic [TW-1:0]         purged;
  logic [UW-1:0]         rd_idx;
  logic [UW-1:0]         wr_idx;
  logic                  pv;
  logic                  seen;
  logic                  hit;
  logic [COUNT_BITS-1:0] hit_cnt;
  mct_status_t           status;

  logic                  issue;
  logic [KEY_W-1:0]      rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  match;
  logic                  keep;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [TW-1:0]         total_scan;
  logic                  append;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [KEY_W-1:0]      wkey;
  logic [COUNT_BITS-1:0] wcnt;
  logic [31:0]           hc_ext;
  logic [31:0]           used_ext;
  logic [63:0]           tot_ext;
  logic [63:0]           pur_ext;

  mct_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wkey),
    .re    (issue),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_key)
  );

  mct_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wcnt),
    .re    (issue),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_cnt)
  );

  always_comb begin
    issue      = (state == S_SCAN) && (rd_idx < used);
    match      = (rd_key == req.key);
    keep       = 1'b1;
    new_cnt    = rd_cnt;
    total_scan = total;
    case (req.cmd)
      CMD_ADD: begin
        if (match && rd_cnt != CNT_MAX) begin
          new_cnt    = rd_cnt + COUNT_BITS'(1);
          total_scan = total + TW'(1);
        end
      end
      CMD_REMOVE: begin
        if (match) begin
          new_cnt    = rd_cnt - COUNT_BITS'(1);
          keep       = (rd_cnt != COUNT_BITS'(1));
          total_scan = total - TW'(1);
        end
      end
      CMD_PURGE: begin
        if (rd_cnt > COUNT_BITS'(1)) begin
          keep       = 1'b0;
          total_scan = total - TW'(rd_cnt);
        end
      end
      default: begin
      end
    endcase

    append = (state == S_FINISH) && (req.cmd == CMD_ADD) && !seen && (used < DEPTH_U);

    if (append) begin
      we    = 1'b1;
      waddr = used[AW-1:0];
      wkey  = req.key;
      wcnt  = COUNT_BITS'(1);
    end else begin
      we    = (state == S_SCAN) && pv && keep;
      waddr = wr_idx[AW-1:0];
      wkey  = rd_key;
      wcnt  = new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      total <= '0;
      pv    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            req     <= req_in;
            rd_idx  <= '0;
            wr_idx  <= '0;
            pv      <= 1'b0;
            seen    <= 1'b0;
            hit     <= 1'b0;
            hit_cnt <= '0;
            purged  <= '0;
            status  <= ST_OK;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          pv <= issue;
          if (issue) begin
            rd_idx <= rd_idx + UW'(1);
          end else begin
            state <= S_FINISH;
          end
          if (pv) begin
            total <= total_scan;
            if (match) begin
              seen <= 1'b1;
              if (req.cmd == CMD_ADD && rd_cnt == CNT_MAX) begin
                status <= ST_SAT;
              end
            end
            if (match && keep) begin
              hit     <= 1'b1;
              hit_cnt <= new_cnt;
            end
            if (keep) begin
              wr_idx <= wr_idx + UW'(1);
            end else if (req.cmd == CMD_PURGE) begin
              purged <= purged + TW'(rd_cnt);
            end
          end
        end
        S_FINISH: begin
          if (append) begin
            used    <= wr_idx + UW'(1);
            total   <= total + TW'(1);
            hit     <= 1'b1;
            hit_cnt <= COUNT_BITS'(1);
          end else begin
            used <= wr_idx;
          end
          if (!seen) begin
            case (req.cmd)
              CMD_ADD: begin
                if (!append) begin
                  status <= ST_FULL;
                end
              end
              CMD_REMOVE, CMD_QUERY: status <= ST_NOT_FOUND;
              default: begin
              end
            endcase
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    hc_ext   = 32'(hit_cnt);
    used_ext = 32'(used);
    tot_ext  = 64'(total);
    pur_ext  = 64'(purged);

    res.status        = status;
    res.present       = hit;
    res.key_count     = !hit ? '0 :
                        (hc_ext > 32'h0000_FFFF) ? 16'hFFFF : hc_ext[15:0];
    res.purged_total  = (pur_ext > 64'h3F_FFFF) ? 22'h3F_FFFF : pur_ext[21:0];
    res.distinct_keys = (used_ext > 32'd127) ? 7'h7F : used_ext[6:0];
    res.total_size    = (tot_ext > 64'h3F_FFFF) ? 22'h3F_FFFF : tot_ext[21:0];
  end

  assign ready     = (state == S_IDLE);
  assign res_valid = (state == S_OUT);

endmodule

`default_nettype wire

[src/multiset_count_table_unit.sv]
// ----------------------------------------------------------------------------
// multiset_count_table_unit
// Bounded key/count table kept in insertion order, with add, remove, query
// and purge of multiples; one result word per command word.
// ----------------------------------------------------------------------------
//  channel | dir | fields (tdata, lsb first)
//  s_      | in  | command[1:0], key[33:2], zero pad
//  m_      | out | status, present, key_count, purged_total,
//          |     | distinct_keys, total_size, zero pad
//
//  A word passes from accept through the scan of the stored entries and a
//  finish step to the result; the next word is taken only once the result
//  has moved into the output register. One pass reads every
//  stored entry once through the single read port of the key and count
//  RAMs, compacting in place behind the read pointer.
//  Reset clears the entry count and total; RAM contents need no clearing.
//  s_tready is low while a word is being worked on; a result waits in
//  the output register while m_tready is low and the next word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module multiset_count_table_unit #(
  parameter int TABLE_DEPTH = mct_pkg::DEF_TABLE_DEPTH,
  parameter int COUNT_BITS  = mct_pkg::DEF_COUNT_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [mct_pkg::IN_TDATA_W-1:0]   s_tdata,   // command, key
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [mct_pkg::OUT_TDATA_W-1:0]  m_tdata    // status, present,
                                                           // key_count, purged_total,
                                                           // distinct_keys, total_size
);
  import mct_pkg::*;

  mct_req_t    req;
  mct_result_t res;
  logic        eng_ready;
  logic        res_valid;
  logic        res_ready;

  assign req.cmd = mct_cmd_t'(s_tdata[1:0]);
  assign req.key = s_tdata[33:2];

  assign s_tready  = eng_ready;
  assign res_ready = !m_tvalid || m_tready;

  mct_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (s_tvalid && eng_ready),
    .req_in    (req),
    .ready     (eng_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {2'b00, res};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_full_absent: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_FULL |-> !res.present && res.key_count == '0)
    else $error("table full result reports the key present");

  a_notfound_absent: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_NOT_FOUND |-> !res.present && res.purged_total == '0)
    else $error("not-found result reports the key present");

  a_present_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.present |-> res.key_count != '0)
    else $error("present key with zero count");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !res_valid)
    else $error("engine took a word while busy");
`endif

endmodule

`default_nettype wire
